// File: src/bitmap_copy_invert_realign_unit_assert.svh
// Assertion macros used by the checker of this block.
`ifndef BITMAP_COPY_INVERT_REALIGN_UNIT_ASSERT_SVH
`define BITMAP_COPY_INVERT_REALIGN_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BCIR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BCIR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/bcir_pkg.sv
package bcir_pkg;

	localparam int LENGTH_WIDTH = 32;
	localparam int BUF_W        = 15;
	localparam int CNT_W        = 4;
	localparam int Q_DEPTH      = 4;
	localparam int Q_PTR_W      = $clog2(Q_DEPTH);
	localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

	typedef enum logic [7:0] {
		REG_SRC_BIT_OFFSET = 8'd0,
		REG_DST_BIT_OFFSET = 8'd1,
		REG_LENGTH_BITS    = 8'd2,
		REG_INVERT         = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             en;
		logic [7:0]       index;
		logic [31:0]      data;
	} cfg_wr_t;

	typedef struct packed {
		logic [7:0] dest_byte;
		logic [7:0] write_mask;
		logic       last;
	} result_t;

	typedef struct packed {
		logic    push_a;
		logic    push_b;
		result_t res_a;
		result_t res_b;
	} push_t;

	typedef struct packed {
		logic [BUF_W-1:0]        buf_bits;
		logic [CNT_W-1:0]        count;
		logic [LENGTH_WIDTH-1:0] out_left;
		logic                    first_out_done;
	} pack_state_t;

	typedef struct packed {
		pack_state_t st;
		result_t     res;
	} emit_t;

	// Take the low byte of the buffer as one destination byte and advance.
	function automatic emit_t emit_byte(pack_state_t st, logic [2:0] dst_off);
		logic [2:0]       start;
		logic [3:0]       ne;
		logic [8:0]       lowm;
		logic [7:0]       mask;
		logic [CNT_W-1:0] used;
		emit_t            r;
		start = st.first_out_done ? 3'd0 : dst_off;
		ne    = 4'd8 - {1'b0, start};
		if ({{(LENGTH_WIDTH-4){1'b0}}, ne} > st.out_left)
			ne = st.out_left[3:0];
		lowm  = (9'd1 << ne) - 9'd1;
		mask  = lowm[7:0] << start;
		r.res.dest_byte      = st.buf_bits[7:0] & mask;
		r.res.write_mask     = mask;
		r.st.out_left        = st.out_left - {{(LENGTH_WIDTH-4){1'b0}}, ne};
		r.res.last           = (r.st.out_left == '0);
		r.st.first_out_done  = 1'b1;
		used                 = (st.count < 4'd8) ? st.count : 4'd8;
		r.st.buf_bits        = {8'd0, st.buf_bits[BUF_W-1:8]};
		r.st.count           = st.count - used;
		return r;
	endfunction

endpackage

// File: src/bcir_align.sv
module bcir_align (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcir_pkg::cfg_wr_t    cfg,
	input  logic                 fire,
	input  logic [7:0]           byte_s1,
	output bcir_pkg::push_t      push
);

	logic [2:0]                        src_off_q;
	logic [2:0]                        dst_off_q;
	logic [bcir_pkg::LENGTH_WIDTH-1:0] length_q;
	logic                              invert_q;

	logic                              seen_q;
	logic [bcir_pkg::LENGTH_WIDTH-1:0] src_left_q;
	bcir_pkg::pack_state_t             st_q;

	logic                              start;
	logic                              take;
	logic [2:0]                        skip;
	logic [3:0]                        n_full;
	logic [3:0]                        n;
	logic [7:0]                        shifted;
	logic [8:0]                        nmask;
	logic [7:0]                        bits;
	logic [bcir_pkg::LENGTH_WIDTH-1:0] src_left0;
	logic [bcir_pkg::LENGTH_WIDTH-1:0] src_left1;
	bcir_pkg::pack_state_t             st0;
	bcir_pkg::pack_state_t             st1;
	bcir_pkg::pack_state_t             st2;
	bcir_pkg::pack_state_t             st3;
	bcir_pkg::emit_t                   ea;
	bcir_pkg::emit_t                   eb;
	logic [63:0]                       data_ext;

	assign data_ext = {32'd0, cfg.data};

	always_comb begin
		start = !seen_q;
		// a zero-length run ignores the byte and starts nothing
		take  = fire && !(start && (length_q == '0));
		skip  = start ? src_off_q : 3'd0;

		st0.buf_bits       = start ? '0 : st_q.buf_bits;
		st0.count          = start ? {1'b0, dst_off_q} : st_q.count;
		st0.out_left       = start ? length_q : st_q.out_left;
		st0.first_out_done = start ? 1'b0 : st_q.first_out_done;
		src_left0          = start ? length_q : src_left_q;

		n_full = 4'd8 - {1'b0, skip};
		if ({{(bcir_pkg::LENGTH_WIDTH-4){1'b0}}, n_full} > src_left0)
			n = src_left0[3:0];
		else
			n = n_full;

		shifted = (byte_s1 >> skip) ^ {8{invert_q}};
		nmask   = (9'd1 << n) - 9'd1;
		bits    = shifted & nmask[7:0];

		st1          = st0;
		st1.buf_bits = st0.buf_bits | ({7'd0, bits} << st0.count);
		st1.count    = st0.count + n;
		src_left1    = src_left0 - {{(bcir_pkg::LENGTH_WIDTH-4){1'b0}}, n};

		ea          = bcir_pkg::emit_byte(st1, dst_off_q);
		push.push_a = take && (st1.count >= 4'd8) && (st1.out_left != '0);
		st2         = push.push_a ? ea.st : st1;

		// flush the partial byte once the last source bits are in
		eb          = bcir_pkg::emit_byte(st2, dst_off_q);
		push.push_b = take && (src_left1 == '0) && (st2.count != '0) && (st2.out_left != '0);
		st3         = push.push_b ? eb.st : st2;

		push.res_a = ea.res;
		push.res_b = eb.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_off_q  <= '0;
			dst_off_q  <= '0;
			length_q   <= '0;
			invert_q   <= 1'b0;
			seen_q     <= 1'b0;
			src_left_q <= '0;
			st_q       <= '0;
		end else if (cfg.en) begin
			case (cfg.index)
				bcir_pkg::REG_SRC_BIT_OFFSET: begin
					src_off_q <= cfg.data[2:0];
					seen_q    <= 1'b0;
					src_left_q <= '0;
					st_q      <= '0;
				end
				bcir_pkg::REG_DST_BIT_OFFSET: begin
					dst_off_q <= cfg.data[2:0];
					seen_q    <= 1'b0;
					src_left_q <= '0;
					st_q      <= '0;
				end
				bcir_pkg::REG_LENGTH_BITS: begin
					length_q  <= data_ext[bcir_pkg::LENGTH_WIDTH-1:0];
					seen_q    <= 1'b0;
					src_left_q <= '0;
					st_q      <= '0;
				end
				bcir_pkg::REG_INVERT: begin
					invert_q  <= cfg.data[0];
					seen_q    <= 1'b0;
					src_left_q <= '0;
					st_q      <= '0;
				end
				default: begin
				end
			endcase
		end else if (take) begin
			if (src_left1 == '0) begin
				seen_q     <= 1'b0;
				src_left_q <= '0;
				st_q       <= '0;
			end else begin
				seen_q     <= 1'b1;
				src_left_q <= src_left1;
				st_q       <= st3;
			end
		end
	end

endmodule

// File: src/bcir_outq.sv
module bcir_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  bcir_pkg::push_t    push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_stall,
	output bcir_pkg::result_t  head
);

	bcir_pkg::result_t            mem [bcir_pkg::Q_DEPTH];
	logic [bcir_pkg::Q_PTR_W-1:0] wr_q;
	logic [bcir_pkg::Q_PTR_W-1:0] rd_q;
	logic [bcir_pkg::Q_CNT_W-1:0] cnt_q;
	logic [bcir_pkg::Q_PTR_W-1:0] wr_b;
	logic [bcir_pkg::Q_CNT_W-1:0] n_push;
	logic                         pop;

	assign out_valid = (cnt_q != '0);
	assign head      = mem[rd_q];
	assign pop       = out_valid && !out_stall;
	// two free slots guarantee a beat's worst case of two results fits
	assign room      = (cnt_q <= bcir_pkg::Q_CNT_W'(bcir_pkg::Q_DEPTH - 2));
	assign wr_b      = push.push_a ? wr_q + 1'b1 : wr_q;
	assign n_push    = bcir_pkg::Q_CNT_W'(push.push_a) + bcir_pkg::Q_CNT_W'(push.push_b);

	always_ff @(posedge clk) begin
		if (push.push_a)
			mem[wr_q] <= push.res_a;
		if (push.push_b)
			mem[wr_b] <= push.res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[bcir_pkg::Q_PTR_W-1:0];
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + n_push - bcir_pkg::Q_CNT_W'(pop);
		end
	end

endmodule

// File: src/bitmap_copy_invert_realign_unit.sv
// A source byte taken into the input register is realigned combinationally once the
// result queue has room; its result beats are written to the queue, raising out_valid.
// Throughput: one source byte per cycle; a byte may add a second beat (the tail flush),
// and the input stalls while the four-entry result queue holds three or more beats.
// Reset (arst_n low, asynchronous) clears registers, run state and the queue.
module bitmap_copy_invert_realign_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  src_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  dest_byte,
	output logic [7:0]  write_mask,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               room;
	logic               fire;
	bcir_pkg::cfg_wr_t  cfg;
	bcir_pkg::push_t    push;
	bcir_pkg::result_t  head;

	assign cfg_ready = 1'b1;
	assign cfg.en    = cfg_valid && cfg_ready;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the byte while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= src_byte;
	end

	bcir_align u_align (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.push    (push)
	);

	bcir_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign dest_byte  = head.dest_byte;
	assign write_mask = head.write_mask;
	assign last       = head.last;

endmodule

// File: src/bcir_checker.sv
`include "bitmap_copy_invert_realign_unit_assert.svh"

module bcir_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  dest_byte,
	input logic [7:0]  write_mask,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	`BCIR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")
	`BCIR_ASSERT_NOW(a_mask_nonzero, out_valid, write_mask != 8'd0, "result beat with empty write mask")
	`BCIR_ASSERT_NOW(a_data_in_mask, out_valid, (dest_byte & ~write_mask) == 8'd0, "data bits set outside write mask")
	`BCIR_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind bitmap_copy_invert_realign_unit bcir_checker u_bcir_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 12;
	localparam int QUIET_CYCLES   = 6;
	localparam int HOLD_CYCLES    = 60;
	localparam int RANDOM_SRC     = 1000;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int NUM_REGS       = 4;
	localparam logic [7:0] LAST_SPARE_INDEX = 8'hFF;

	typedef enum logic [1:0] {SRC_BEAT, REG_WRITE, SETTLE} plan_op_t;
	typedef struct {
		plan_op_t    op;
		logic [7:0]  value;
		logic [7:0]  index;
		logic [31:0] data;
	} plan_entry_t;

	typedef enum logic [1:0] {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_TOGGLE} pace_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [7:0]  src_byte   = 8'd0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [7:0]  dest_byte;
	logic [7:0]  write_mask;
	logic        last;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index  = 8'd0;
	logic [31:0] cfg_data   = 32'd0;

	plan_entry_t       copy_plan_q[$];
	bcir_pkg::result_t dest_q[$];
	int unsigned       err_cnt = 0;

	// realignment state mirrored from the block
	logic [2:0]  src_off_sh = 3'd0;
	logic [2:0]  dst_off_sh = 3'd0;
	logic [31:0] len_sh     = 32'd0;
	logic        inv_sh     = 1'b0;
	logic [14:0] acc_bits   = 15'd0;
	int unsigned acc_cnt    = 0;
	logic [31:0] src_left   = 32'd0;
	logic [31:0] out_left   = 32'd0;
	logic        run_on     = 1'b0;
	logic        head_done  = 1'b0;

	int unsigned gap_left   = 0;
	int unsigned burst_left = 0;
	int unsigned quiet_cnt  = 0;

	pace_t       pace       = PACE_FREE;
	int unsigned pace_left  = 0;
	int unsigned hold_left  = 0;
	int unsigned hold_cool  = 300;

	bitmap_copy_invert_realign_unit DUT (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.src_byte,
		.out_valid,
		.out_stall,
		.dest_byte,
		.write_mask,
		.last,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
		$display("== FAIL ==");
		$finish;
	end

	task automatic clear_run();
		acc_bits  = 15'd0;
		acc_cnt   = 0;
		src_left  = 32'd0;
		out_left  = 32'd0;
		run_on    = 1'b0;
		head_done = 1'b0;
	endtask

	task automatic load_register(input logic [7:0] idx, input logic [31:0] d);
		case (idx)
			bcir_pkg::REG_SRC_BIT_OFFSET: src_off_sh = d[2:0];
			bcir_pkg::REG_DST_BIT_OFFSET: dst_off_sh = d[2:0];
			bcir_pkg::REG_LENGTH_BITS:    len_sh     = d;
			bcir_pkg::REG_INVERT:         inv_sh     = d[0];
			default:                      return;
		endcase
		// any valid write aborts the run in progress
		clear_run();
	endtask

	task automatic emit_dest();
		int unsigned       start;
		int unsigned       nb;
		logic [7:0]        m;
		bcir_pkg::result_t r;
		start = head_done ? 0 : dst_off_sh;
		nb = 8 - start;
		if (nb > out_left)
			nb = out_left;
		m = 8'(((32'd1 << nb) - 32'd1) << start);
		r.dest_byte  = acc_bits[7:0] & m;
		r.write_mask = m;
		out_left     = out_left - nb;
		r.last       = (out_left == 32'd0);
		head_done    = 1'b1;
		acc_bits     = acc_bits >> 8;
		acc_cnt      = acc_cnt - ((acc_cnt < 8) ? acc_cnt : 8);
		dest_q.push_back(r);
	endtask

	task automatic realign_byte(input logic [7:0] b);
		int unsigned skip;
		int unsigned nb;
		logic [31:0] bits;
		skip = 0;
		if (!run_on) begin
			// a zero-length run never starts; the byte is dropped
			if (len_sh == 32'd0)
				return;
			run_on    = 1'b1;
			head_done = 1'b0;
			src_left  = len_sh;
			out_left  = len_sh;
			acc_bits  = 15'd0;
			acc_cnt   = dst_off_sh;
			skip      = src_off_sh;
		end
		nb = 8 - skip;
		if (nb > src_left)
			nb = src_left;
		bits = 32'(b) >> skip;
		if (inv_sh)
			bits = ~bits;
		bits = bits & ((32'd1 << nb) - 32'd1);
		acc_bits = 15'(32'(acc_bits) | (bits << acc_cnt));
		acc_cnt  = acc_cnt + nb;
		src_left = src_left - nb;
		while (acc_cnt >= 8 && out_left != 32'd0)
			emit_dest();
		// flush the partial tail byte
		if (src_left == 32'd0 && acc_cnt > 0 && out_left != 32'd0)
			emit_dest();
		if (src_left == 32'd0)
			clear_run();
	endtask

	always @(posedge clk) begin : drive_src
		logic        nxt_valid;
		logic        nxt_cfg;
		logic [7:0]  nxt_byte;
		logic [7:0]  nxt_index;
		logic [31:0] nxt_data;
		if (arst_n) begin
			nxt_valid = in_valid;
			nxt_byte  = src_byte;
			nxt_cfg   = cfg_valid;
			nxt_index = cfg_index;
			nxt_data  = cfg_data;
			if (in_valid && !in_stall) begin
				realign_byte(src_byte);
				nxt_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				load_register(cfg_index, cfg_data);
				nxt_cfg = 1'b0;
			end
			if (!nxt_valid && !nxt_cfg && copy_plan_q.size() != 0) begin
				if (copy_plan_q[0].op == SRC_BEAT) begin
					if (gap_left != 0) begin
						gap_left--;
					end else begin
						nxt_valid = 1'b1;
						nxt_byte  = copy_plan_q[0].value;
						copy_plan_q.delete(0);
						if (burst_left != 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(0, 40);
							gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
						end
					end
				end else if (dest_q.size() != 0) begin
					quiet_cnt = 0;
				end else if (quiet_cnt < QUIET_CYCLES) begin
					// let a byte with no result finish inside the block
					quiet_cnt++;
				end else begin
					quiet_cnt = 0;
					if (copy_plan_q[0].op == REG_WRITE) begin
						nxt_cfg   = 1'b1;
						nxt_index = copy_plan_q[0].index;
						nxt_data  = copy_plan_q[0].data;
					end
					copy_plan_q.delete(0);
				end
			end
			in_valid  <= nxt_valid;
			src_byte  <= nxt_byte;
			cfg_valid <= nxt_cfg;
			cfg_index <= nxt_index;
			cfg_data  <= nxt_data;
		end
	end

	always @(posedge clk) begin : pace_dest
		logic busy;
		if (arst_n) begin
			if (pace_left == 0) begin
				pace      = pace_t'($urandom_range(0, 3));
				pace_left = $urandom_range(10, 200);
			end else begin
				pace_left--;
			end
			// hold off for a long stretch while bytes keep coming, so the block backs up
			if (hold_left != 0)
				hold_left--;
			else if (hold_cool != 0)
				hold_cool--;
			else if (in_valid && $urandom_range(0, 31) == 0) begin
				hold_left = HOLD_CYCLES;
				hold_cool = 3000;
			end
			case (pace)
				PACE_FREE:  busy = 1'b0;
				PACE_LIGHT: busy = ($urandom_range(0, 3) == 0);
				PACE_HEAVY: busy = ($urandom_range(0, 3) != 0);
				default:    busy = ~out_stall;
			endcase
			out_stall <= busy || (hold_left != 0);
		end
	end

	always @(posedge clk) begin : watch_dest
		bcir_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (dest_q.size() == 0) begin
				$error("dest beat %h mask %h with none expected", dest_byte, write_mask);
				err_cnt++;
			end else begin
				want = dest_q.pop_front();
				if (dest_byte !== want.dest_byte) begin
					$error("dest_byte: expected %h, got %h", want.dest_byte, dest_byte);
					err_cnt++;
				end
				if (write_mask !== want.write_mask) begin
					$error("write_mask: expected %h, got %h", want.write_mask, write_mask);
					err_cnt++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					err_cnt++;
				end
			end
		end
	end

	task automatic add_src(input logic [7:0] v);
		copy_plan_q.push_back('{op: SRC_BEAT, value: v, index: 8'd0, data: 32'd0});
	endtask

	task automatic add_reg(input logic [7:0] idx, input logic [31:0] d);
		copy_plan_q.push_back('{op: REG_WRITE, value: 8'd0, index: idx, data: d});
	endtask

	task automatic add_settle();
		copy_plan_q.push_back('{op: SETTLE, value: 8'd0, index: 8'd0, data: 32'd0});
	endtask

	task automatic program_copy(input logic [2:0] s, input logic [2:0] d,
			input logic [31:0] len, input logic inv, input logic noisy);
		logic [31:0] junk;
		junk = noisy ? $urandom : 32'd0;
		add_reg(bcir_pkg::REG_SRC_BIT_OFFSET, {junk[31:3], s});
		junk = noisy ? $urandom : 32'd0;
		add_reg(bcir_pkg::REG_DST_BIT_OFFSET, {junk[31:3], d});
		add_reg(bcir_pkg::REG_LENGTH_BITS, len);
		junk = noisy ? $urandom : 32'd0;
		add_reg(bcir_pkg::REG_INVERT, {junk[31:1], inv});
	endtask

	initial begin : plan_and_finish
		logic [2:0]      cur_s;
		logic [2:0]      cur_d;
		logic            cur_inv;
		logic [31:0]     cur_len;
		logic [31:0]     new_len;
		logic [31:0]     junk;
		longint unsigned full;
		int unsigned     nbytes;
		int unsigned     runs;
		int unsigned     run_i;
		int unsigned     pick;
		int unsigned     src_total;
		int unsigned     wait_cyc;

		// single full byte, aligned
		program_copy(3'd0, 3'd0, 32'd8, 1'b0, 1'b0);
		add_src(8'hA5);
		// zero length: bytes are dropped
		program_copy(3'd0, 3'd0, 32'd0, 1'b0, 1'b0);
		add_src(8'hFF);
		add_src(8'h00);
		// two beats from one byte, inverted
		program_copy(3'd0, 3'd7, 32'd16, 1'b1, 1'b0);
		add_src(8'h00);
		add_src(8'hFF);
		program_copy(3'd7, 3'd7, 32'd10, 1'b0, 1'b0);
		add_src(8'h80);
		add_src(8'hFF);
		add_src(8'h5A);
		program_copy(3'd3, 3'd5, 32'd13, 1'b1, 1'b0);
		add_src(8'h3C);
		add_src(8'hC3);
		// back-to-back runs with no reprogramming
		program_copy(3'd2, 3'd1, 32'd5, 1'b0, 1'b0);
		add_src(8'h7E);
		add_src(8'h81);
		add_src(8'hFF);
		program_copy(3'd5, 3'd2, 32'd1, 1'b0, 1'b0);
		add_src(8'h20);
		// endless run, a spare index that must not disturb it, then abort by reprogramming
		program_copy(3'd1, 3'd3, 32'hFFFF_FFFF, 1'b1, 1'b0);
		add_src(8'h12);
		add_src(8'h34);
		add_src(8'h56);
		add_src(8'h78);
		add_reg(LAST_SPARE_INDEX, 32'hFFFF_FFFF);
		add_src(8'h9A);
		add_settle();

		cur_s     = 3'd1;
		cur_d     = 3'd3;
		cur_inv   = 1'b1;
		cur_len   = 32'hFFFF_FFFF;
		src_total = 0;
		while (src_total < RANDOM_SRC) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				new_len = 32'd0;
			else if (pick < 80)
				new_len = $urandom_range(1, 64);
			else if (pick < 92)
				new_len = $urandom_range(65, 600);
			else if (pick < 97)
				new_len = $urandom | 32'h8000_0000;
			else
				new_len = 32'hFFFF_FFFF;
			if ($urandom_range(0, 4) == 0) begin
				// touch one register only
				junk = $urandom;
				case (bcir_pkg::cfg_reg_t'($urandom_range(0, NUM_REGS - 1)))
					bcir_pkg::REG_SRC_BIT_OFFSET: begin
						cur_s = junk[2:0];
						add_reg(bcir_pkg::REG_SRC_BIT_OFFSET, junk);
					end
					bcir_pkg::REG_DST_BIT_OFFSET: begin
						cur_d = junk[2:0];
						add_reg(bcir_pkg::REG_DST_BIT_OFFSET, junk);
					end
					bcir_pkg::REG_LENGTH_BITS: begin
						cur_len = new_len;
						add_reg(bcir_pkg::REG_LENGTH_BITS, cur_len);
					end
					default: begin
						cur_inv = junk[0];
						add_reg(bcir_pkg::REG_INVERT, junk);
					end
				endcase
			end else begin
				cur_s   = 3'($urandom);
				cur_d   = 3'($urandom);
				cur_inv = 1'($urandom);
				cur_len = new_len;
				program_copy(cur_s, cur_d, cur_len, cur_inv, 1'b1);
			end
			if ($urandom_range(0, 19) == 0)
				add_reg(8'($urandom_range(NUM_REGS, 255)), $urandom);
			runs = $urandom_range(1, 3);
			for (run_i = 0; run_i < runs; run_i++) begin
				if (cur_len == 32'd0) begin
					repeat ($urandom_range(1, 3)) add_src(8'($urandom));
					break;
				end
				full = (64'(cur_s) + 64'(cur_len) + 64'd7) / 64'd8;
				if (cur_len > 32'd600)
					nbytes = $urandom_range(1, 24);
				else if ($urandom_range(0, 9) == 0)
					nbytes = $urandom_range(1, 32'(full));
				else
					nbytes = 32'(full);
				repeat (nbytes) add_src(8'($urandom));
				src_total += nbytes;
				// a cut-short run stays open until the next register write
				if (nbytes < full)
					break;
			end
			if ($urandom_range(0, 9) == 0)
				add_settle();
		end

		while (copy_plan_q.size() != 0 || in_valid || cfg_valid)
			@(posedge clk);
		for (wait_cyc = 0; wait_cyc < DRAIN_LIMIT && dest_q.size() != 0; wait_cyc++)
			@(posedge clk);
		repeat (QUIET_CYCLES * 2) @(posedge clk);
		if (dest_q.size() != 0) begin
			$error("%0d dest beats never arrived", dest_q.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/bcir_pkg.sv
src/bcir_align.sv
src/bcir_outq.sv
src/bitmap_copy_invert_realign_unit.sv
src/bcir_checker.sv
dv/tb_top.sv
